>>> rtl/zbaf_pkg.sv
package zbaf_pkg;

  // Default sizes of the frame store.
  localparam int MAX_WIDTH_DEF  = 512;
  localparam int MAX_HEIGHT_DEF = 512;
  localparam int ACCUM_BITS_DEF = 32;

  // Fixed field widths.
  localparam int OP_W      = 2;
  localparam int POS_W     = 9;
  localparam int COLOR_W   = 16;
  localparam int DEPTH_W   = 16;
  localparam int BYTE_W    = 8;
  localparam int STATUS_W  = 2;
  localparam int FRAME_W   = 10;
  localparam int CFG_IDX_W = 2;
  localparam int KIND_W    = 3;
  localparam int FRAC_BITS = 12;

  localparam logic [FRAME_W-1:0] FRAME_RESET = 10'd512;

  // Operation codes of an input transaction.
  typedef enum logic [OP_W-1:0] {
    OP_CLEAR   = 2'd0,
    OP_PUT     = 2'd1,
    OP_RESOLVE = 2'd2,
    OP_NONE    = 2'd3
  } op_t;

  // Classified work handed from the front end to the back end.
  typedef enum logic [KIND_W-1:0] {
    K_CLEAR   = 3'd0,
    K_PUT     = 3'd1,
    K_RESOLVE = 3'd2,
    K_NONE    = 3'd3,
    K_OUTSIDE = 3'd4
  } kind_t;

  // Result status codes.
  localparam logic [STATUS_W-1:0] ST_DONE    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_OUTSIDE = 2'd1;
  localparam logic [STATUS_W-1:0] ST_REJECT  = 2'd2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_MODE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 2'd2;

endpackage

>>> rtl/zbaf_front.sv
module zbaf_front #(
  parameter int MAX_WIDTH  = 512,
  parameter int MAX_HEIGHT = 512,
  parameter int AW         = 18,
  parameter int IW         = 85
) (
  input  logic [zbaf_pkg::OP_W-1:0]    op,
  input  logic [zbaf_pkg::POS_W-1:0]   x_pos,
  input  logic [zbaf_pkg::POS_W-1:0]   y_pos,
  input  logic [zbaf_pkg::COLOR_W-1:0] red_in,
  input  logic [zbaf_pkg::COLOR_W-1:0] green_in,
  input  logic [zbaf_pkg::COLOR_W-1:0] blue_in,
  input  logic [zbaf_pkg::DEPTH_W-1:0] depth_or_samples,
  input  logic [zbaf_pkg::FRAME_W-1:0] frame_width,
  input  logic [zbaf_pkg::FRAME_W-1:0] frame_height,
  output logic [IW-1:0]                item
);
  import zbaf_pkg::*;

  logic          outside;
  logic [AW-1:0] addr;
  kind_t         kind;

  // Bounds check against both the programmed frame and the store size.
  assign outside = ({1'b0, x_pos} >= frame_width) || ({1'b0, y_pos} >= frame_height) ||
                   (32'(x_pos) >= 32'(MAX_WIDTH)) || (32'(y_pos) >= 32'(MAX_HEIGHT));

  // Row-major pixel address.
  assign addr = AW'(32'(y_pos) * 32'(MAX_WIDTH) + 32'(x_pos));

  // Classify the operation.
  always_comb begin
    unique case (op_t'(op))
      OP_CLEAR:   kind = K_CLEAR;
      OP_PUT:     kind = outside ? K_OUTSIDE : K_PUT;
      OP_RESOLVE: kind = outside ? K_OUTSIDE : K_RESOLVE;
      default:    kind = K_NONE;
    endcase
  end

  assign item = {kind, addr, red_in, green_in, blue_in, depth_or_samples};

endmodule

>>> rtl/zbaf_queue.sv
module zbaf_queue #(
  parameter int DW = 85
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  logic [DW-1:0] din,
  output logic          full,
  input  logic          pop,
  output logic [DW-1:0] dout,
  output logic          empty
);

  logic [DW-1:0] slots [2];
  logic          wp;
  logic          rp;
  logic [1:0]    cnt;

  assign full  = (cnt == 2'd2);
  assign empty = (cnt == 2'd0);
  assign dout  = slots[rp];

  // Two-entry queue pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= 1'b0;
      rp  <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (push) wp <= ~wp;
      if (pop) rp <= ~rp;
      cnt <= cnt + 2'(push) - 2'(pop);
    end
  end

  // Payload storage.
  always_ff @(posedge clk) begin
    if (push) slots[wp] <= din;
  end

endmodule

>>> rtl/zbaf_back.sv
module zbaf_back #(
  parameter int MAX_WIDTH  = 512,
  parameter int MAX_HEIGHT = 512,
  parameter int ACCUM_BITS = 32,
  parameter int AW         = 18,
  parameter int IW         = 85
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          q_empty,
  input  logic [IW-1:0]                 q_data,
  output logic                          q_pop,
  input  logic                          accumulate_mode,
  output logic                          init_busy,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [zbaf_pkg::STATUS_W-1:0] status,
  output logic [zbaf_pkg::BYTE_W-1:0]   red_out,
  output logic [zbaf_pkg::BYTE_W-1:0]   green_out,
  output logic [zbaf_pkg::BYTE_W-1:0]   blue_out
);
  import zbaf_pkg::*;

  localparam int NPIX = MAX_WIDTH * MAX_HEIGHT;
  localparam int A    = ACCUM_BITS;
  localparam int EW   = 3 * A + DEPTH_W;
  localparam int RW   = (A + 8 > 36) ? A + 8 : 36;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_READ  = 6'b000010,
    S_EXEC  = 6'b000100,
    S_DIV   = 6'b001000,
    S_OUT   = 6'b010000,
    S_CLEAR = 6'b100000
  } state_t;

  state_t               state;
  logic                 clr_report;
  logic [AW-1:0]        clr_addr;
  logic [IW-1:0]        cur;
  logic [2:0]           div_cnt;
  logic [RW-1:0]        rem [3];
  logic [RW-1:0]        dsh;
  logic [BYTE_W-1:0]    quo [3];
  logic [2:0]           sat;
  logic [DEPTH_W-1:0]   sample_count;

  logic [EW-1:0]        mem [NPIX];
  logic [EW-1:0]        rd_q;
  logic                 mem_we;
  logic [AW-1:0]        mem_addr;
  logic [EW-1:0]        mem_wdata;

  kind_t                q_kind;
  logic [AW-1:0]        cur_addr;
  logic [COLOR_W-1:0]   col [3];
  logic [DEPTH_W-1:0]   cur_dos;
  logic [A-1:0]         acc [3];
  logic [DEPTH_W-1:0]   old_depth;
  logic [A-1:0]         acc_sum [3];
  logic [A:0]           wide_sum [3];
  logic                 depth_win;
  logic [RW-1:0]        divisor;
  logic [DEPTH_W-1:0]   n_eff;
  logic                 ge [3];
  logic [BYTE_W-1:0]    quo_nx [3];

  function automatic logic q_kind_put(input logic [IW-1:0] it);
    return kind_t'(it[IW-1 -: KIND_W]) == K_PUT;
  endfunction

  // Field unpacking of the queued transaction and the stored entry.
  assign q_kind    = kind_t'(q_data[IW-1 -: KIND_W]);
  assign cur_addr  = cur[IW-KIND_W-1 -: AW];
  assign col[0]    = cur[63:48];
  assign col[1]    = cur[47:32];
  assign col[2]    = cur[31:16];
  assign cur_dos   = cur[15:0];
  assign acc[0]    = rd_q[EW-1 -: A];
  assign acc[1]    = rd_q[EW-1-A -: A];
  assign acc[2]    = rd_q[DEPTH_W+A-1 -: A];
  assign old_depth = rd_q[DEPTH_W-1:0];

  // Saturating accumulation and divider step per channel.
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      wide_sum[c] = {1'b0, acc[c]} + (A+1)'(col[c]);
      acc_sum[c]  = wide_sum[c][A] ? {A{1'b1}} : wide_sum[c][A-1:0];
      ge[c]       = (rem[c] >= dsh);
      quo_nx[c]   = {quo[c][BYTE_W-2:0], ge[c]};
    end
  end

  assign depth_win = (cur_dos > old_depth);
  assign n_eff     = (sample_count == '0) ? DEPTH_W'(1) : sample_count;
  assign divisor   = RW'(n_eff) << FRAC_BITS;

  // Store write port: clearing sweep or put update.
  always_comb begin
    mem_we    = 1'b0;
    mem_addr  = cur_addr;
    mem_wdata = '0;
    if (state == S_CLEAR) begin
      mem_we   = 1'b1;
      mem_addr = clr_addr;
    end else if (state == S_EXEC && q_kind_put(cur)) begin
      if (accumulate_mode) begin
        mem_we    = 1'b1;
        mem_wdata = {acc_sum[0], acc_sum[1], acc_sum[2], old_depth};
      end else if (depth_win) begin
        mem_we    = 1'b1;
        mem_wdata = {A'(col[0]), A'(col[1]), A'(col[2]), cur_dos};
      end
    end
  end

  // Frame store with registered read.
  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_addr] <= mem_wdata;
    if (state == S_READ) rd_q <= mem[cur_addr];
  end

  assign q_pop     = (state == S_IDLE) && !q_empty;
  assign out_valid = (state == S_OUT);
  assign init_busy = (state == S_CLEAR) && !clr_report;

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_CLEAR;
      clr_report   <= 1'b0;
      clr_addr     <= '0;
      sample_count <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (!q_empty) begin
            cur       <= q_data;
            status    <= ST_DONE;
            red_out   <= '0;
            green_out <= '0;
            blue_out  <= '0;
            case (q_kind) inside
              K_CLEAR: begin
                clr_addr   <= '0;
                clr_report <= 1'b1;
                state      <= S_CLEAR;
              end
              K_PUT, K_RESOLVE: state <= S_READ;
              K_OUTSIDE: begin
                status <= ST_OUTSIDE;
                state  <= S_OUT;
              end
              default: state <= S_OUT;
            endcase
          end
        end
        S_READ: state <= S_EXEC;
        S_EXEC: begin
          if (q_kind_put(cur)) begin
            if (accumulate_mode) begin
              sample_count <= cur_dos;
            end else if (!depth_win) begin
              status <= ST_REJECT;
            end
            state <= S_OUT;
          end else begin
            // Quotient is below 256 whenever the channel does not saturate.
            for (int c = 0; c < 3; c++) begin
              sat[c] <= (RW'(acc[c]) >= divisor);
              rem[c] <= (RW'(acc[c]) << 8) - RW'(acc[c]);
              quo[c] <= '0;
            end
            dsh     <= divisor << 7;
            div_cnt <= '0;
            state   <= S_DIV;
          end
        end
        S_DIV: begin
          for (int c = 0; c < 3; c++) begin
            if (ge[c]) rem[c] <= rem[c] - dsh;
            quo[c] <= quo_nx[c];
          end
          dsh     <= dsh >> 1;
          div_cnt <= div_cnt + 3'd1;
          if (div_cnt == 3'd7) begin
            red_out   <= sat[0] ? {BYTE_W{1'b1}} : quo_nx[0];
            green_out <= sat[1] ? {BYTE_W{1'b1}} : quo_nx[1];
            blue_out  <= sat[2] ? {BYTE_W{1'b1}} : quo_nx[2];
            state     <= S_OUT;
          end
        end
        S_OUT: begin
          if (!out_stall) state <= S_IDLE;
        end
        S_CLEAR: begin
          clr_addr <= clr_addr + AW'(1);
          if (clr_addr == AW'(NPIX - 1)) begin
            state <= clr_report ? S_OUT : S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Checks.
  a_we_src: assert property (@(posedge clk) disable iff (rst)
    mem_we |-> (state == S_EXEC || state == S_CLEAR))
    else $error("store written outside put or clear");

  a_init: assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> init_busy)
    else $error("no clearing sweep after reset");

  a_div: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV) |=> (state == S_DIV || state == S_OUT))
    else $error("divider left early");

  a_exec: assert property (@(posedge clk) disable iff (rst)
    (state == S_EXEC) |-> ($past(state) == S_READ))
    else $error("execute without store read");

endmodule

>>> rtl/zbuffer_accum_framebuffer.sv
// Z-buffer framebuffer with accumulation.
// Input channel (in_valid/in_stall) carries op, x_pos, y_pos, three Q4.12
// colors and a depth or sample count; a transaction is accepted when
// in_valid is high and in_stall low. Every accepted transaction gives
// exactly one result on the output channel (out_valid/out_stall): status
// and three resolved color bytes.
// Configuration is a plain write port (cfg_we, cfg_index, cfg_data) with
// mode, frame width and frame height; write it only while idle.
// A two-entry queue separates the classifying front end from the store
// sequencer, so new transactions are taken while a result waits.
// From the queue head, a put passes the read and execute states, and a
// resolve adds an 8-step divider per channel, sharing one shifted divisor;
// a clear sweeps all MAX_WIDTH*MAX_HEIGHT pixels, since the single store
// write port zeroes one pixel per cycle. Transactions are carried out one
// at a time. After reset the store is cleared by the same sweep, and
// in_stall stays high until it ends.
// While the receiver stalls, the result is held and the queue fills, then
// in_stall rises.
module zbuffer_accum_framebuffer #(
  parameter int MAX_WIDTH  = zbaf_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = zbaf_pkg::MAX_HEIGHT_DEF,
  parameter int ACCUM_BITS = zbaf_pkg::ACCUM_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [zbaf_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [zbaf_pkg::FRAME_W-1:0]   cfg_data,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [zbaf_pkg::OP_W-1:0]      op,
  input  logic [zbaf_pkg::POS_W-1:0]     x_pos,
  input  logic [zbaf_pkg::POS_W-1:0]     y_pos,
  input  logic [zbaf_pkg::COLOR_W-1:0]   red_in,
  input  logic [zbaf_pkg::COLOR_W-1:0]   green_in,
  input  logic [zbaf_pkg::COLOR_W-1:0]   blue_in,
  input  logic [zbaf_pkg::DEPTH_W-1:0]   depth_or_samples,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [zbaf_pkg::STATUS_W-1:0]  status,
  output logic [zbaf_pkg::BYTE_W-1:0]    red_out,
  output logic [zbaf_pkg::BYTE_W-1:0]    green_out,
  output logic [zbaf_pkg::BYTE_W-1:0]    blue_out
);
  import zbaf_pkg::*;

  localparam int NPIX = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW   = (NPIX > 1) ? $clog2(NPIX) : 1;
  localparam int IW   = KIND_W + AW + 3 * COLOR_W + DEPTH_W;

  logic                accumulate_mode;
  logic [FRAME_W-1:0]  frame_width;
  logic [FRAME_W-1:0]  frame_height;
  logic [IW-1:0]       item;
  logic [IW-1:0]       q_data;
  logic                q_full;
  logic                q_empty;
  logic                q_pop;
  logic                push;
  logic                init_busy;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      accumulate_mode <= 1'b0;
      frame_width     <= FRAME_RESET;
      frame_height    <= FRAME_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_MODE:   accumulate_mode <= cfg_data[0];
        CFG_WIDTH:  frame_width     <= cfg_data;
        CFG_HEIGHT: frame_height    <= cfg_data;
        default:    ;
      endcase
    end
  end

  assign in_stall = q_full || init_busy;
  assign push     = in_valid && !in_stall;

  zbaf_front #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_HEIGHT(MAX_HEIGHT),
    .AW        (AW),
    .IW        (IW)
  ) u_front (
    .op              (op),
    .x_pos           (x_pos),
    .y_pos           (y_pos),
    .red_in          (red_in),
    .green_in        (green_in),
    .blue_in         (blue_in),
    .depth_or_samples(depth_or_samples),
    .frame_width     (frame_width),
    .frame_height    (frame_height),
    .item            (item)
  );

  zbaf_queue #(
    .DW(IW)
  ) u_queue (
    .clk  (clk),
    .rst  (rst),
    .push (push),
    .din  (item),
    .full (q_full),
    .pop  (q_pop),
    .dout (q_data),
    .empty(q_empty)
  );

  zbaf_back #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_HEIGHT(MAX_HEIGHT),
    .ACCUM_BITS(ACCUM_BITS),
    .AW        (AW),
    .IW        (IW)
  ) u_back (
    .clk            (clk),
    .rst            (rst),
    .q_empty        (q_empty),
    .q_data         (q_data),
    .q_pop          (q_pop),
    .accumulate_mode(accumulate_mode),
    .init_busy      (init_busy),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .status         (status),
    .red_out        (red_out),
    .green_out      (green_out),
    .blue_out       (blue_out)
  );

endmodule
